// ----- rtl/core/iwdg_pkg.sv -----
// Package for the independent watchdog: codes, keys, item types and helpers.
package iwdg_pkg;

  localparam int SyncTicksDef = 3;
  localparam int CountBitsDef = 12;
  localparam int SyncCntW     = 4;
  localparam int DivW         = 8;
  localparam int DataW        = 16;
  localparam int InTdataW     = 24;
  localparam int OutTdataW    = 24;

  localparam logic [DataW-1:0] KeyUnlock = 16'h5555;
  localparam logic [DataW-1:0] KeyReload = 16'hAAAA;
  localparam logic [DataW-1:0] KeyStart  = 16'hCCCC;

  typedef enum logic [1:0] {
    OpTick  = 2'd0,
    OpWrite = 2'd1,
    OpRead  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    AddrKey      = 2'd0,
    AddrPrescale = 2'd1,
    AddrReload   = 2'd2,
    AddrStatus   = 2'd3
  } addr_e;

  typedef struct packed {
    op_e              opcode;
    addr_e            reg_addr;
    logic [DataW-1:0] write_data;
    logic             debug_halt;
  } item_t;

  typedef struct packed {
    logic [DataW-1:0] read_data;
    logic             timeout_reset;
    logic             is_running;
  } result_t;

  // Divide ratio 4 << code, capped at 256.
  function automatic logic [DivW:0] divisor_of(input logic [2:0] code);
    logic [DivW:0] d;
    d = 9'd256;
    if (code < 3'd7) begin
      d = 9'd4 << code;
    end
    return d;
  endfunction

endpackage

// ----- rtl/core/independent_watchdog.sv -----
// Top level of the independent watchdog: input register, update core, output register.
// A request passes through the input register and then the output register before it appears on the master side.
// Throughput: one request per cycle while m_axis_tready holds; the state update is one pass through the core.
// While a result waits in the output register, the input register can still take one new request.
// Reset (rst_ni low, asynchronous): watchdog stopped, registers locked, reload and
// counter all ones, freeze_on_halt cleared; no clearing pass is needed.
module independent_watchdog #(
  parameter int SYNC_TICKS = iwdg_pkg::SyncTicksDef,
  parameter int COUNT_BITS = iwdg_pkg::CountBitsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic                             cfg_wdata_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [1:0] reg_addr, [17:2] write_data, [18] debug_halt, [23:19] zero
  input  logic [iwdg_pkg::InTdataW-1:0]    s_axis_tdata,
  // [1:0] opcode
  input  logic [1:0]                       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [15:0] read_data, [16] timeout_reset, [17] is_running, [23:18] zero
  output logic [iwdg_pkg::OutTdataW-1:0]   m_axis_tdata
);

  logic              in_valid_q;
  iwdg_pkg::item_t   in_item_q;
  logic              out_valid_q, out_valid_d;
  iwdg_pkg::result_t out_res_q;
  iwdg_pkg::result_t core_res;
  logic              adv;

  assign adv           = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;
  assign out_valid_d   = adv || (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item_q.opcode     <= iwdg_pkg::op_e'(s_axis_tuser);
      in_item_q.reg_addr   <= iwdg_pkg::addr_e'(s_axis_tdata[1:0]);
      in_item_q.write_data <= s_axis_tdata[17:2];
      in_item_q.debug_halt <= s_axis_tdata[18];
    end
    if (adv) begin
      out_res_q <= core_res;
    end
  end

  iwdg_core #(
    .SYNC_TICKS(SYNC_TICKS),
    .COUNT_BITS(COUNT_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .adv_i      (adv),
    .item_i     (in_item_q),
    .res_o      (core_res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_res_q.is_running, out_res_q.timeout_reset,
                          out_res_q.read_data};

endmodule

// ----- rtl/core/iwdg_core.sv -----
// Watchdog state registers and the single-pass update for one request.
module iwdg_core #(
  parameter int SYNC_TICKS = iwdg_pkg::SyncTicksDef,
  parameter int COUNT_BITS = iwdg_pkg::CountBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  logic              adv_i,
  input  iwdg_pkg::item_t   item_i,
  output iwdg_pkg::result_t res_o
);

  localparam logic [iwdg_pkg::SyncCntW-1:0] SyncLoad = iwdg_pkg::SyncCntW'(SYNC_TICKS);

  logic                          freeze_q;
  logic                          running_q, running_d;
  logic                          unlocked_q, unlocked_d;
  logic [2:0]                    pre_wr_q, pre_wr_d;
  logic [COUNT_BITS-1:0]         rld_wr_q, rld_wr_d;
  logic [2:0]                    pre_act_q, pre_act_d;
  logic [COUNT_BITS-1:0]         rld_act_q, rld_act_d;
  logic [COUNT_BITS-1:0]         count_q, count_d;
  logic [iwdg_pkg::DivW-1:0]     div_q, div_d;
  logic                          pre_busy_q, pre_busy_d;
  logic                          rld_busy_q, rld_busy_d;
  logic [iwdg_pkg::SyncCntW-1:0] pre_sync_q, pre_sync_d;
  logic [iwdg_pkg::SyncCntW-1:0] rld_sync_q, rld_sync_d;
  logic [iwdg_pkg::DataW-1:0]    rdata;
  logic                          timeout;

  always_comb begin
    running_d  = running_q;
    unlocked_d = unlocked_q;
    pre_wr_d   = pre_wr_q;
    rld_wr_d   = rld_wr_q;
    pre_act_d  = pre_act_q;
    rld_act_d  = rld_act_q;
    count_d    = count_q;
    div_d      = div_q;
    pre_busy_d = pre_busy_q;
    rld_busy_d = rld_busy_q;
    pre_sync_d = pre_sync_q;
    rld_sync_d = rld_sync_q;
    rdata      = '0;
    timeout    = 1'b0;
    case (item_i.opcode)
      iwdg_pkg::OpTick: begin
        if (!(freeze_q && item_i.debug_halt)) begin
          if (pre_busy_q) begin
            if (pre_sync_q != '0) begin
              pre_sync_d = pre_sync_q - 1'b1;
            end
            if (pre_sync_d == '0) begin
              pre_act_d  = pre_wr_q;
              pre_busy_d = 1'b0;
            end
          end
          if (rld_busy_q) begin
            if (rld_sync_q != '0) begin
              rld_sync_d = rld_sync_q - 1'b1;
            end
            if (rld_sync_d == '0) begin
              rld_act_d  = rld_wr_q;
              rld_busy_d = 1'b0;
            end
          end
          if (running_q) begin
            if ({1'b0, div_q} + 1'b1 >= iwdg_pkg::divisor_of(pre_act_d)) begin
              div_d = '0;
              if (count_q == '0) begin
                timeout    = 1'b1;
                running_d  = 1'b0;
                unlocked_d = 1'b0;
                pre_wr_d   = '0;
                rld_wr_d   = '1;
                pre_act_d  = '0;
                rld_act_d  = '1;
                count_d    = '1;
                pre_busy_d = 1'b0;
                rld_busy_d = 1'b0;
                pre_sync_d = '0;
                rld_sync_d = '0;
              end else begin
                count_d = count_q - 1'b1;
              end
            end else begin
              div_d = div_q + 1'b1;
            end
          end
        end
      end
      iwdg_pkg::OpWrite: begin
        unique case (item_i.reg_addr)
          iwdg_pkg::AddrKey: begin
            if (item_i.write_data == iwdg_pkg::KeyUnlock) begin
              unlocked_d = 1'b1;
            end else begin
              unlocked_d = 1'b0;
              if (item_i.write_data == iwdg_pkg::KeyReload) begin
                count_d = rld_act_q;
              end else if (item_i.write_data == iwdg_pkg::KeyStart) begin
                running_d = 1'b1;
              end
            end
          end
          iwdg_pkg::AddrPrescale: begin
            if (unlocked_q && !pre_busy_q) begin
              pre_wr_d   = item_i.write_data[2:0];
              pre_busy_d = 1'b1;
              pre_sync_d = SyncLoad;
            end
          end
          iwdg_pkg::AddrReload: begin
            if (unlocked_q && !rld_busy_q) begin
              rld_wr_d   = item_i.write_data[COUNT_BITS-1:0];
              rld_busy_d = 1'b1;
              rld_sync_d = SyncLoad;
            end
          end
          default: ;
        endcase
      end
      iwdg_pkg::OpRead: begin
        unique case (item_i.reg_addr)
          iwdg_pkg::AddrPrescale: rdata = iwdg_pkg::DataW'(pre_wr_q);
          iwdg_pkg::AddrReload:   rdata = iwdg_pkg::DataW'(rld_wr_q);
          iwdg_pkg::AddrStatus:   rdata = iwdg_pkg::DataW'({rld_busy_q, pre_busy_q});
          default:                rdata = '0;
        endcase
      end
      default: ;
    endcase
  end

  assign res_o.read_data     = rdata;
  assign res_o.timeout_reset = timeout;
  assign res_o.is_running    = running_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freeze_q <= 1'b0;
    end else if (cfg_we_i) begin
      freeze_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q  <= 1'b0;
      unlocked_q <= 1'b0;
      pre_wr_q   <= '0;
      rld_wr_q   <= '1;
      pre_act_q  <= '0;
      rld_act_q  <= '1;
      count_q    <= '1;
      div_q      <= '0;
      pre_busy_q <= 1'b0;
      rld_busy_q <= 1'b0;
      pre_sync_q <= '0;
      rld_sync_q <= '0;
    end else if (adv_i) begin
      running_q  <= running_d;
      unlocked_q <= unlocked_d;
      pre_wr_q   <= pre_wr_d;
      rld_wr_q   <= rld_wr_d;
      pre_act_q  <= pre_act_d;
      rld_act_q  <= rld_act_d;
      count_q    <= count_d;
      div_q      <= div_d;
      pre_busy_q <= pre_busy_d;
      rld_busy_q <= rld_busy_d;
      pre_sync_q <= pre_sync_d;
      rld_sync_q <= rld_sync_d;
    end
  end

  a_stop_only_on_timeout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(running_q) |-> $past(adv_i && timeout))
    else $error("watchdog stopped without a timeout");

  a_div_idle_when_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !running_q |-> div_q == '0)
    else $error("divider moved while stopped");

  a_pre_sync_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pre_busy_q |-> pre_sync_q == '0)
    else $error("prescaler sync count left over");

  a_rld_sync_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rld_busy_q |-> rld_sync_q == '0)
    else $error("reload sync count left over");

endmodule
